>>> rtl/mme_pkg.sv
package mme_pkg;

  // Matrix dimension and derived widths.
  localparam int DIM      = 8;
  localparam int IDX_W    = 3;                    // row / column field width
  localparam int K_W      = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W   = $clog2(DIM * DIM);
  localparam int ELEM_W   = 16;                   // signed Q8.8
  localparam int PROD_W   = 2 * ELEM_W;           // signed Q16.16 product
  localparam int ACC_W    = 38;                   // signed Q22.16 sum
  localparam int CMD_W    = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic           write_a;   // store element into A
    logic           write_b;   // store element into B
    logic           start;     // latch coordinates, clear accumulator
    logic           issue;     // read A[row][k] and B[k][col]
    logic [K_W-1:0] k;
    logic           finish;    // load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/mme_ctrl.sv
module mme_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [mme_pkg::CMD_W-1:0] command,
  input  mme_pkg::dp_status_t      status,
  output mme_pkg::dp_cmd_t         cmd
);

  mme_pkg::state_t         state, state_next;
  logic [mme_pkg::K_W-1:0] k, k_next;
  logic                    accept;
  mme_pkg::cmd_e_t         kind;

  assign kind   = mme_pkg::cmd_e_t'(command);
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    k_next     = k;
    case (state)
      mme_pkg::ST_IDLE: begin
        k_next = '0;
        if (accept && kind == mme_pkg::CMD_COMPUTE) state_next = mme_pkg::ST_ISSUE;
      end
      mme_pkg::ST_ISSUE: begin
        if (int'(k) == mme_pkg::DIM - 1) begin
          state_next = mme_pkg::ST_DRAIN;
          k_next     = '0;
        end else begin
          k_next = k + 1'b1;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (status.pipe_empty && status.out_free) state_next = mme_pkg::ST_IDLE;
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.k       = k;
    case (state)
      mme_pkg::ST_IDLE: begin
        s_tready    = !rst;  // no request taken while in reset
        cmd.write_a = accept && kind == mme_pkg::CMD_WRITE_A;
        cmd.write_b = accept && kind == mme_pkg::CMD_WRITE_B;
        cmd.start   = accept && kind == mme_pkg::CMD_COMPUTE;
      end
      mme_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      mme_pkg::ST_DRAIN: begin
        cmd.finish = status.pipe_empty && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/mme_datapath.sv
module mme_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mme_pkg::dp_cmd_t                  cmd,
  output mme_pkg::dp_status_t               status,
  input  logic [mme_pkg::IDX_W-1:0]         row_index,
  input  logic [mme_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mme_pkg::ELEM_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mme_pkg::ACC_W-1:0]  product_value,
  output logic [mme_pkg::IDX_W-1:0]         out_row,
  output logic [mme_pkg::IDX_W-1:0]         out_col
);

  logic [mme_pkg::ELEM_W-1:0] mem_a [mme_pkg::DIM*mme_pkg::DIM];
  logic [mme_pkg::ELEM_W-1:0] mem_b [mme_pkg::DIM*mme_pkg::DIM];

  logic                              in_range;
  logic [mme_pkg::ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic [mme_pkg::IDX_W-1:0]         row_q, col_q;
  logic                              range_q;
  logic signed [mme_pkg::ELEM_W-1:0] rd_a, rd_b;
  logic                              rd_vld, prod_vld;
  logic signed [mme_pkg::PROD_W-1:0] prod;
  logic signed [mme_pkg::ACC_W-1:0]  acc;

  assign in_range  = (int'(row_index) < mme_pkg::DIM) && (int'(col_index) < mme_pkg::DIM);
  assign wr_addr   = mme_pkg::ADDR_W'(int'(row_index) * mme_pkg::DIM + int'(col_index));
  assign rd_addr_a = mme_pkg::ADDR_W'(int'(row_q) * mme_pkg::DIM + int'(cmd.k));
  assign rd_addr_b = mme_pkg::ADDR_W'(int'(cmd.k) * mme_pkg::DIM + int'(col_q));

  // A store, one write and one read port.
  always_ff @(posedge clk) begin
    if (cmd.write_a && in_range) mem_a[wr_addr] <= element_value;
    if (cmd.issue) rd_a <= mem_a[rd_addr_a];
  end

  // B store.
  always_ff @(posedge clk) begin
    if (cmd.write_b && in_range) mem_b[wr_addr] <= element_value;
    if (cmd.issue) rd_b <= mem_b[rd_addr_b];
  end

  // Request coordinates.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q   <= row_index;
      col_q   <= col_index;
      range_q <= in_range;
    end
  end

  // Read -> multiply -> accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) prod <= rd_a * rd_b;
    if (cmd.start) acc <= '0;
    else if (prod_vld) acc <= acc + mme_pkg::ACC_W'(prod);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      product_value <= range_q ? acc : '0;
      out_row       <= row_q;
      out_col       <= col_q;
    end
  end

  assign status.pipe_empty = !rd_vld && !prod_vld;
  assign status.out_free   = !out_valid || out_ready;

endmodule

>>> rtl/matrix_multiply_engine.sv
// Dense 8x8 matrix multiply engine. Requests come in on the s_ stream: tuser
// carries the kind (write A element, write B element, compute C element, and
// an unused code that is dropped) and tdata carries row, column and a signed
// Q8.8 element. A write returns nothing. A compute returns one result on the
// m_ stream: the exact signed Q22.16 sum of A[row][k]*B[k][col] over all k,
// plus the coordinates. Each compute walks the two element memories with one
// multiply-accumulate per cycle and holds the input until its DIM reads are
// done and the read, multiply and add stages drain. The result register frees
// the input side while a result waits on m_tready; a following compute stalls
// only at its end if the previous result is still unclaimed. Reading an element
// that was never written gives an undefined sum.
module matrix_multiply_engine (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mme_pkg::IN_DATA_W-1:0]      s_tdata,  // row_index[2:0], col_index[5:3],
                                                       // element_value[21:6], zero pad
  input  logic [mme_pkg::CMD_W-1:0]          s_tuser,  // command[1:0]
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mme_pkg::OUT_DATA_W-1:0]     m_tdata   // product_value[37:0],
                                                       // out_row[40:38], out_col[43:41], pad
);

  localparam int ROW_LSB = 0;
  localparam int COL_LSB = ROW_LSB + mme_pkg::IDX_W;
  localparam int VAL_LSB = COL_LSB + mme_pkg::IDX_W;
  localparam int PAD_W   = mme_pkg::OUT_DATA_W - mme_pkg::ACC_W - 2 * mme_pkg::IDX_W;

  mme_pkg::dp_cmd_t                  cmd;
  mme_pkg::dp_status_t               status;
  logic signed [mme_pkg::ACC_W-1:0]  product_value;
  logic [mme_pkg::IDX_W-1:0]         out_row, out_col;

  // Sequencer: accepts requests, steps k over the dot product, hands off result.
  mme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  // Element memories, MAC pipeline and result register.
  mme_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row_index     (s_tdata[ROW_LSB +: mme_pkg::IDX_W]),
    .col_index     (s_tdata[COL_LSB +: mme_pkg::IDX_W]),
    .element_value (s_tdata[VAL_LSB +: mme_pkg::ELEM_W]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col)
  );

  assign m_tdata = {{PAD_W{1'b0}}, out_col, out_row, product_value};

endmodule

>>> test/matrix_multiply_engine_tb.sv
`timescale 1ns / 100ps

// Stimulus and checking for the 8x8 multiply engine. A short table of
// requests drives full-scale products and the dropped command code. Then
// about 700 random requests follow: element writes and compute requests,
// where a compute only touches a row of A and a column of B that are
// fully written. Every result is checked against an in-bench copy of both
// element stores or against a sum typed into the table.
module matrix_multiply_engine_tb;

  localparam int N_RANDOM     = 700;
  localparam int N_ELEMS      = mme_pkg::DIM * mme_pkg::DIM;
  localparam int DRAIN_CYCLES = mme_pkg::DIM + 3 + 20;
  localparam int WAIT_LIMIT   = 20000;

  // Full-scale case: eight products of -128.0 * -128.0 in Q8.8 give a raw Q22.16 sum of 2^33.
  localparam logic [mme_pkg::ACC_W-1:0] SUM_ALL_MIN = 38'h02_0000_0000;

  typedef struct {
    mme_pkg::cmd_e_t            cmd;
    logic [mme_pkg::IDX_W-1:0]  row;
    logic [mme_pkg::IDX_W-1:0]  col;
    logic [mme_pkg::ELEM_W-1:0] value;
  } request_t;

  typedef struct {
    logic [mme_pkg::ACC_W-1:0] sum;
    logic [mme_pkg::IDX_W-1:0] row;
    logic [mme_pkg::IDX_W-1:0] col;
  } c_elem_t;

  typedef struct {
    request_t                  req;
    bit                        typed;  // sum below is the expected one
    logic [mme_pkg::ACC_W-1:0] sum;
  } stim_row_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mme_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic [mme_pkg::CMD_W-1:0]      s_tuser  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mme_pkg::OUT_DATA_W-1:0] m_tdata;

  matrix_multiply_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench copy of both element stores, plus which entries hold a value.
  logic signed [mme_pkg::ELEM_W-1:0] a_elems [N_ELEMS];
  logic signed [mme_pkg::ELEM_W-1:0] b_elems [N_ELEMS];
  bit [N_ELEMS-1:0]                  a_written = '0;
  bit [N_ELEMS-1:0]                  b_written = '0;

  c_elem_t   pending_c [$];
  stim_row_t directed [$];
  int        fail_count     = 0;
  bit        steady_stretch = 1'b0;  // no gaps on either side while set

  function automatic logic [mme_pkg::ACC_W-1:0] dot_row_col(int r, int c);
    longint acc = 0;
    for (int k = 0; k < mme_pkg::DIM; k++)
      acc += longint'(a_elems[r*mme_pkg::DIM+k]) * longint'(b_elems[k*mme_pkg::DIM+c]);
    return acc[mme_pkg::ACC_W-1:0];
  endfunction

  function automatic bit c_elem_defined(int r, int c);
    for (int k = 0; k < mme_pkg::DIM; k++)
      if (!a_written[r*mme_pkg::DIM+k] || !b_written[k*mme_pkg::DIM+c]) return 1'b0;
    return 1'b1;
  endfunction

  // Update the store copies for one accepted request and queue its result.
  function automatic void absorb_request(request_t req, bit typed,
                                         logic [mme_pkg::ACC_W-1:0] typed_sum);
    c_elem_t c;
    int      idx;
    idx = int'(req.row) * mme_pkg::DIM + int'(req.col);
    case (req.cmd)
      mme_pkg::CMD_WRITE_A: begin
        a_elems[idx]   = req.value;
        a_written[idx] = 1'b1;
      end
      mme_pkg::CMD_WRITE_B: begin
        b_elems[idx]   = req.value;
        b_written[idx] = 1'b1;
      end
      mme_pkg::CMD_COMPUTE: begin
        c.sum = typed ? typed_sum : dot_row_col(int'(req.row), int'(req.col));
        c.row = req.row;
        c.col = req.col;
        pending_c.push_back(c);
      end
      default: ;  // dropped code
    endcase
  endfunction

  function automatic void add_row(mme_pkg::cmd_e_t cmd, int r, int c,
                                  logic [mme_pkg::ELEM_W-1:0] v,
                                  bit typed, logic [mme_pkg::ACC_W-1:0] sum);
    stim_row_t s;
    s.req.cmd   = cmd;
    s.req.row   = mme_pkg::IDX_W'(r);
    s.req.col   = mme_pkg::IDX_W'(c);
    s.req.value = v;
    s.typed     = typed;
    s.sum       = sum;
    directed.push_back(s);
  endfunction

  // Mostly zero, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (steady_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Half the time prefer a slot not yet written, so coverage fills fast.
  function automatic int pick_slot(bit [N_ELEMS-1:0] written);
    int start;
    int idx;
    start = $urandom_range(0, N_ELEMS - 1);
    if (~written != '0 && $urandom_range(0, 1) == 1) begin
      for (int i = 0; i < N_ELEMS; i++) begin
        idx = (start + i) % N_ELEMS;
        if (!written[idx]) return idx;
      end
    end
    return start;
  endfunction

  task automatic send_request(request_t req, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.cmd;
    s_tdata  <= {2'b00, req.value, req.col, req.row};
    do @(posedge clk); while (!s_tready);
  endtask

  // Result side stalls.
  initial begin
    int stall;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Result check against the oldest queued expectation.
  always @(posedge clk) begin
    c_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_c.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_c.pop_front();
        if (m_tdata[mme_pkg::ACC_W-1:0] !== want.sum) begin
          $display("%0t: product_value mismatch, expected %h actual %h",
                   $time, want.sum, m_tdata[mme_pkg::ACC_W-1:0]);
          fail_count++;
        end
        if (m_tdata[mme_pkg::ACC_W+mme_pkg::IDX_W-1:mme_pkg::ACC_W] !== want.row) begin
          $display("%0t: out_row mismatch, expected %0d actual %0d",
                   $time, want.row, m_tdata[mme_pkg::ACC_W+mme_pkg::IDX_W-1:mme_pkg::ACC_W]);
          fail_count++;
        end
        if (m_tdata[mme_pkg::ACC_W+2*mme_pkg::IDX_W-1:mme_pkg::ACC_W+mme_pkg::IDX_W]
            !== want.col) begin
          $display("%0t: out_col mismatch, expected %0d actual %0d",
                   $time, want.col,
                   m_tdata[mme_pkg::ACC_W+2*mme_pkg::IDX_W-1:mme_pkg::ACC_W+mme_pkg::IDX_W]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    request_t req;
    int       sent;
    int       r;
    int       idx;
    int       start;
    int       waited;
    bit       found;

    // Row 7 of A and column 7 of B at the most negative element.
    for (int k = 0; k < mme_pkg::DIM; k++)
      add_row(mme_pkg::CMD_WRITE_A, 7, k, 16'h8000, 1'b0, '0);
    for (int k = 0; k < mme_pkg::DIM; k++)
      add_row(mme_pkg::CMD_WRITE_B, k, 7, 16'h8000, 1'b0, '0);
    add_row(mme_pkg::CMD_COMPUTE, 7, 7, 16'h0000, 1'b1, SUM_ALL_MIN);
    // The unused code must not disturb the stores.
    add_row(mme_pkg::CMD_UNUSED,  7, 7, 16'h7FFF, 1'b0, '0);
    add_row(mme_pkg::CMD_COMPUTE, 7, 7, 16'hFFFF, 1'b1, SUM_ALL_MIN);
    // Mix in the most positive element.
    add_row(mme_pkg::CMD_WRITE_A, 7, 0, 16'h7FFF, 1'b0, '0);
    add_row(mme_pkg::CMD_COMPUTE, 7, 7, 16'h0000, 1'b0, '0);
    add_row(mme_pkg::CMD_WRITE_B, 0, 7, 16'h7FFF, 1'b0, '0);
    add_row(mme_pkg::CMD_COMPUTE, 7, 7, 16'h0000, 1'b0, '0);
    add_row(mme_pkg::CMD_WRITE_A, 7, 1, 16'h0000, 1'b0, '0);
    add_row(mme_pkg::CMD_COMPUTE, 7, 7, 16'h0000, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_request(directed[i].req, pick_gap());
      absorb_request(directed[i].req, directed[i].typed, directed[i].sum);
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      steady_stretch = (sent % 150) >= 110;
      req.row   = mme_pkg::IDX_W'($urandom_range(0, mme_pkg::DIM - 1));
      req.col   = mme_pkg::IDX_W'($urandom_range(0, mme_pkg::DIM - 1));
      req.value = mme_pkg::ELEM_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        req.cmd = mme_pkg::CMD_UNUSED;
      end else begin
        found = 1'b0;
        if (r < 45) begin
          start = $urandom_range(0, N_ELEMS - 1);
          for (int t = 0; t < N_ELEMS && !found; t++) begin
            idx = (start + t) % N_ELEMS;
            if (c_elem_defined(idx / mme_pkg::DIM, idx % mme_pkg::DIM)) found = 1'b1;
          end
        end
        if (found) begin
          req.cmd = mme_pkg::CMD_COMPUTE;
        end else begin
          req.cmd = ($urandom_range(0, 1) == 1) ? mme_pkg::CMD_WRITE_B : mme_pkg::CMD_WRITE_A;
          idx = pick_slot(req.cmd == mme_pkg::CMD_WRITE_A ? a_written : b_written);
          r = $urandom_range(0, 99);
          if (r < 10)      req.value = 16'h8000;
          else if (r < 20) req.value = 16'h7FFF;
          else if (r < 25) req.value = 16'h0000;
          else if (r < 30) req.value = 16'hFFFF;
        end
        req.row = mme_pkg::IDX_W'(idx / mme_pkg::DIM);
        req.col = mme_pkg::IDX_W'(idx % mme_pkg::DIM);
        sent++;
      end
      send_request(req, pick_gap());
      absorb_request(req, 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    steady_stretch = 1'b0;

    waited = 0;
    while (pending_c.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_c.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_c.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_c.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/mme_pkg.sv
rtl/mme_ctrl.sv
rtl/mme_datapath.sv
rtl/matrix_multiply_engine.sv
test/matrix_multiply_engine_tb.sv
